/* rtl/rv32i_instruction_decoder_core_defines.svh */
// Assertion macros shared by the instruction decoder RTL
`ifndef RV32I_INSTRUCTION_DECODER_CORE_DEFINES_SVH
`define RV32I_INSTRUCTION_DECODER_CORE_DEFINES_SVH

// Same-cycle implication, checked outside reset
`define RVDEC_ASSERT_SAME(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("rvdec same-cycle check failed");

// Next-cycle implication, checked outside reset
`define RVDEC_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("rvdec next-cycle check failed");

`endif

/* rtl/rvdec_pkg.sv */
// Package with opcode constants, instruction identifiers and decode tables
`default_nettype none

package rvdec_pkg;

	// Major opcodes
	localparam logic [6:0] OP_LOAD     = 7'h03;
	localparam logic [6:0] OP_MISC_MEM = 7'h0f;
	localparam logic [6:0] OP_IMM      = 7'h13;
	localparam logic [6:0] OP_AUIPC    = 7'h17;
	localparam logic [6:0] OP_STORE    = 7'h23;
	localparam logic [6:0] OP_REG      = 7'h33;
	localparam logic [6:0] OP_LUI      = 7'h37;
	localparam logic [6:0] OP_BRANCH   = 7'h63;
	localparam logic [6:0] OP_JALR     = 7'h67;
	localparam logic [6:0] OP_JAL      = 7'h6f;
	localparam logic [6:0] OP_SYSTEM   = 7'h73;

	// funct3 selectors that need a second look
	localparam logic [2:0] F3_ADD_SUB     = 3'd0;
	localparam logic [2:0] F3_SHIFT_RIGHT = 3'd5;
	localparam logic [2:0] F3_PRIV        = 3'd0;
	localparam logic [2:0] F3_FENCE       = 3'd0;
	localparam logic [2:0] F3_FENCE_I     = 3'd1;

	// funct7 selectors
	localparam logic [6:0] F7_BASE = 7'h00;
	localparam logic [6:0] F7_ALT  = 7'h20;

	// Privileged immediates
	localparam logic [11:0] IMM_ECALL  = 12'd0;
	localparam logic [11:0] IMM_EBREAK = 12'd1;

	// Instruction identifiers, zero is the fault code
	typedef enum logic [5:0] {
		ID_FAULT, ID_LB, ID_LH, ID_LW, ID_LBU, ID_LHU, ID_FENCE, ID_FENCE_I,
		ID_ADDI, ID_SLLI, ID_SLTI, ID_SLTIU, ID_XORI, ID_SRLI, ID_SRAI, ID_ORI,
		ID_ANDI, ID_AUIPC, ID_SB, ID_SH, ID_SW, ID_ADD, ID_SUB, ID_SLL,
		ID_SLT, ID_SLTU, ID_XOR, ID_SRL, ID_SRA, ID_OR, ID_AND, ID_LUI,
		ID_BEQ, ID_BNE, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU, ID_JALR, ID_JAL,
		ID_ECALL, ID_EBREAK, ID_CSRRW, ID_CSRRS, ID_CSRRC, ID_CSRRWI,
		ID_CSRRSI, ID_CSRRCI
	} instr_id_t;

	// funct3-indexed lookup tables per opcode
	localparam instr_id_t LOAD_TBL [8] = '{
		ID_LB, ID_LH, ID_LW, ID_FAULT, ID_LBU, ID_LHU, ID_FAULT, ID_FAULT
	};
	localparam instr_id_t IMM_TBL [8] = '{
		ID_ADDI, ID_SLLI, ID_SLTI, ID_SLTIU, ID_XORI, ID_FAULT, ID_ORI, ID_ANDI
	};
	localparam instr_id_t STORE_TBL [8] = '{
		ID_SB, ID_SH, ID_SW, ID_FAULT, ID_FAULT, ID_FAULT, ID_FAULT, ID_FAULT
	};
	localparam instr_id_t REG_TBL [8] = '{
		ID_FAULT, ID_SLL, ID_SLT, ID_SLTU, ID_XOR, ID_FAULT, ID_OR, ID_AND
	};
	localparam instr_id_t BRANCH_TBL [8] = '{
		ID_BEQ, ID_BNE, ID_FAULT, ID_FAULT, ID_BLT, ID_BGE, ID_BLTU, ID_BGEU
	};
	localparam instr_id_t SYSTEM_TBL [8] = '{
		ID_FAULT, ID_CSRRW, ID_CSRRS, ID_CSRRC, ID_FAULT, ID_CSRRWI, ID_CSRRSI,
		ID_CSRRCI
	};

	// Decoded result of one instruction
	typedef struct packed {
		logic [6:0]  opcode_field;
		logic [4:0]  dest_reg;
		logic [2:0]  func3_field;
		logic [4:0]  src1_reg;
		logic [4:0]  src2_reg;
		logic [6:0]  func7_field;
		logic [19:0] upper_field;
		instr_id_t   instr_id;
		logic        fault_flag;
	} dec_result_t;

endpackage

`default_nettype wire

/* rtl/rv32i_instruction_decoder_core.sv */
// Top level of the RV32I instruction decoder: input register, decode, result register
//
// Decodes one 32-bit RV32I instruction word per transaction into its fixed fields,
// a format-dependent upper field and an instruction identifier (0 = fault).
// One instruction is accepted every cycle while in_stall is low; its result reaches
// the outputs through the input register and then the result register, and the
// throughput is one per cycle as long as out_stall stays low. in_stall rises only
// when both registers hold a transaction and the output side is stalling. No
// configuration, no state beyond the two pipeline registers, no clearing after reset.
`default_nettype none

`include "rv32i_instruction_decoder_core_defines.svh"

module rv32i_instruction_decoder_core (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [31:0] instruction_word,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic [6:0]       opcode_field,
	output logic [4:0]       dest_reg,
	output logic [2:0]       func3_field,
	output logic [4:0]       src1_reg,
	output logic [4:0]       src2_reg,
	output logic [6:0]       func7_field,
	output logic [19:0]      upper_field,
	output logic [5:0]       instr_id,
	output logic             fault_flag
);

	logic                   valid_s1;
	logic [31:0]            word_s1;
	logic                   valid_s2;
	rvdec_pkg::dec_result_t res_s2;
	rvdec_pkg::dec_result_t dec;
	logic                   adv_s1;
	logic                   adv_s2;

	logic [6:0]             op;
	logic [2:0]             f3;
	logic [11:0]            i12;
	logic [6:0]             f7;
	rvdec_pkg::instr_id_t   id;
	logic [19:0]            upper;
	logic                   op_known;

	// Advance each stage when its downstream slot is free or draining
	assign adv_s2   = !valid_s2 || !out_stall;
	assign adv_s1   = !valid_s1 || adv_s2;
	assign in_stall = !adv_s1;

	// Capture the incoming instruction
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (adv_s1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			word_s1 <= instruction_word;
		end
	end

	// Split the fixed fields
	assign op  = word_s1[6:0];
	assign f3  = word_s1[14:12];
	assign i12 = word_s1[31:20];
	assign f7  = word_s1[31:25];

	// Decode the instruction identifier and select the upper field by format
	always_comb begin
		upper = word_s1[31:12];
		id    = rvdec_pkg::ID_FAULT;
		unique case (op)
			rvdec_pkg::OP_LOAD: begin
				upper = {8'd0, i12};
				id    = rvdec_pkg::LOAD_TBL[f3];
			end
			rvdec_pkg::OP_MISC_MEM: begin
				upper = {8'd0, i12};
				if (f3 == rvdec_pkg::F3_FENCE) begin
					id = rvdec_pkg::ID_FENCE;
				end else if (f3 == rvdec_pkg::F3_FENCE_I) begin
					id = rvdec_pkg::ID_FENCE_I;
				end
			end
			rvdec_pkg::OP_IMM: begin
				if (f3 == rvdec_pkg::F3_SHIFT_RIGHT) begin
					upper = {13'd0, f7};
					if (f7 == rvdec_pkg::F7_BASE) begin
						id = rvdec_pkg::ID_SRLI;
					end else if (f7 == rvdec_pkg::F7_ALT) begin
						id = rvdec_pkg::ID_SRAI;
					end
				end else begin
					upper = {8'd0, i12};
					id    = rvdec_pkg::IMM_TBL[f3];
				end
			end
			rvdec_pkg::OP_AUIPC: begin
				id = rvdec_pkg::ID_AUIPC;
			end
			rvdec_pkg::OP_STORE: begin
				upper = {13'd0, f7};
				id    = rvdec_pkg::STORE_TBL[f3];
			end
			rvdec_pkg::OP_REG: begin
				upper = {13'd0, f7};
				if (f3 == rvdec_pkg::F3_ADD_SUB) begin
					if (f7 == rvdec_pkg::F7_BASE) begin
						id = rvdec_pkg::ID_ADD;
					end else if (f7 == rvdec_pkg::F7_ALT) begin
						id = rvdec_pkg::ID_SUB;
					end
				end else if (f3 == rvdec_pkg::F3_SHIFT_RIGHT) begin
					if (f7 == rvdec_pkg::F7_BASE) begin
						id = rvdec_pkg::ID_SRL;
					end else if (f7 == rvdec_pkg::F7_ALT) begin
						id = rvdec_pkg::ID_SRA;
					end
				end else begin
					id = rvdec_pkg::REG_TBL[f3];
				end
			end
			rvdec_pkg::OP_LUI: begin
				id = rvdec_pkg::ID_LUI;
			end
			rvdec_pkg::OP_BRANCH: begin
				upper = {13'd0, f7};
				id    = rvdec_pkg::BRANCH_TBL[f3];
			end
			rvdec_pkg::OP_JALR: begin
				id = rvdec_pkg::ID_JALR;
			end
			rvdec_pkg::OP_JAL: begin
				id = rvdec_pkg::ID_JAL;
			end
			rvdec_pkg::OP_SYSTEM: begin
				upper = {8'd0, i12};
				if (f3 == rvdec_pkg::F3_PRIV) begin
					if (i12 == rvdec_pkg::IMM_ECALL) begin
						id = rvdec_pkg::ID_ECALL;
					end else if (i12 == rvdec_pkg::IMM_EBREAK) begin
						id = rvdec_pkg::ID_EBREAK;
					end
				end else begin
					id = rvdec_pkg::SYSTEM_TBL[f3];
				end
			end
			default: begin
				id = rvdec_pkg::ID_FAULT;
			end
		endcase
	end

	// Assemble the result
	always_comb begin
		dec.opcode_field = op;
		dec.dest_reg     = word_s1[11:7];
		dec.func3_field  = f3;
		dec.src1_reg     = word_s1[19:15];
		dec.src2_reg     = word_s1[24:20];
		dec.func7_field  = f7;
		dec.upper_field  = upper;
		dec.instr_id     = id;
		dec.fault_flag   = (id == rvdec_pkg::ID_FAULT);
	end

	// Hold the result until the output transaction completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (adv_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2 && valid_s1) begin
			res_s2 <= dec;
		end
	end

	// Drive the output ports
	assign out_valid    = valid_s2;
	assign opcode_field = res_s2.opcode_field;
	assign dest_reg     = res_s2.dest_reg;
	assign func3_field  = res_s2.func3_field;
	assign src1_reg     = res_s2.src1_reg;
	assign src2_reg     = res_s2.src2_reg;
	assign func7_field  = res_s2.func7_field;
	assign upper_field  = res_s2.upper_field;
	assign instr_id     = res_s2.instr_id;
	assign fault_flag   = res_s2.fault_flag;

	// Recognize the major opcodes on the output side
	assign op_known = (opcode_field == rvdec_pkg::OP_LOAD) ||
		(opcode_field == rvdec_pkg::OP_MISC_MEM) ||
		(opcode_field == rvdec_pkg::OP_IMM) ||
		(opcode_field == rvdec_pkg::OP_AUIPC) ||
		(opcode_field == rvdec_pkg::OP_STORE) ||
		(opcode_field == rvdec_pkg::OP_REG) ||
		(opcode_field == rvdec_pkg::OP_LUI) ||
		(opcode_field == rvdec_pkg::OP_BRANCH) ||
		(opcode_field == rvdec_pkg::OP_JALR) ||
		(opcode_field == rvdec_pkg::OP_JAL) ||
		(opcode_field == rvdec_pkg::OP_SYSTEM);

	// Fault flag agrees with the identifier
	`RVDEC_ASSERT_SAME(a_fault_matches_id, out_valid, fault_flag == (instr_id == rvdec_pkg::ID_FAULT))

	// Unknown opcodes always decode as a fault
	`RVDEC_ASSERT_SAME(a_unknown_op_faults, out_valid && !op_known, fault_flag)

	// Input backpressure only when both stages are full and the output stalls
	`RVDEC_ASSERT_SAME(a_stall_only_when_full, in_stall, valid_s1 && valid_s2 && out_stall)

	// A decoded instruction reaches the result register when it is free
	`RVDEC_ASSERT_NEXT(a_s1_moves_on, valid_s1 && !(valid_s2 && out_stall), out_valid)

endmodule

`default_nettype wire
